// File: hdl/segment_intersection_test_assert.svh
// Assertion macros shared by the segment intersection checker.
`ifndef SEGMENT_INTERSECTION_TEST_ASSERT_SVH
`define SEGMENT_INTERSECTION_TEST_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define SEGINT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define SEGINT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/segint_pkg.sv
// Types and constants of the segment intersection test pipeline.
package segint_pkg;

   localparam int COORD_WIDTH      = 16;
   localparam int DELTA_WIDTH      = COORD_WIDTH + 1;
   localparam int CROSS_PROD_WIDTH = 2 * DELTA_WIDTH;
   localparam int CROSS_WIDTH      = CROSS_PROD_WIDTH + 1;
   localparam int DOT_PROD_WIDTH   = COORD_WIDTH + DELTA_WIDTH;
   localparam int DOT_WIDTH        = DOT_PROD_WIDTH + 1;

   localparam logic [1:0] REL_CROSSING  = 2'd0;
   localparam logic [1:0] REL_PARALLEL  = 2'd1;
   localparam logic [1:0] REL_COLLINEAR = 2'd2;

   typedef logic signed [COORD_WIDTH-1:0]      coord_type;
   typedef logic signed [DELTA_WIDTH-1:0]      delta_type;
   typedef logic signed [CROSS_PROD_WIDTH-1:0] cross_prod_type;
   typedef logic signed [CROSS_WIDTH-1:0]      cross_type;
   typedef logic signed [DOT_PROD_WIDTH-1:0]   dot_prod_type;
   typedef logic signed [DOT_WIDTH-1:0]        dot_type;

   typedef struct packed {
      coord_type a_start_x;
      coord_type a_start_y;
      coord_type a_end_x;
      coord_type a_end_y;
      coord_type b_start_x;
      coord_type b_start_y;
      coord_type b_end_x;
      coord_type b_end_y;
   } req_type;

   typedef struct packed {
      logic       hit;
      logic [1:0] relation;
   } rsp_type;

   // First stage: direction and offset vectors next to the endpoints.
   typedef struct packed {
      req_type   pts;
      delta_type dx;
      delta_type dy;
      delta_type ex;
      delta_type ey;
      delta_type px;
      delta_type py;
   } diff_type;

   // Second stage: every partial product of the cross and dot products.
   typedef struct packed {
      cross_prod_type den_p;
      cross_prod_type den_q;
      cross_prod_type nl_p;
      cross_prod_type nl_q;
      cross_prod_type nm_p;
      cross_prod_type nm_q;
      dot_prod_type   s0_x;
      dot_prod_type   s0_y;
      dot_prod_type   s1_x;
      dot_prod_type   s1_y;
      dot_prod_type   t0_x;
      dot_prod_type   t0_y;
      dot_prod_type   t1_x;
      dot_prod_type   t1_y;
      logic           a_point;
      logic           b_point;
      logic           p_zero;
   } prod_type;

   // Third stage: finished cross products and projections.
   typedef struct packed {
      cross_type den;
      cross_type nl;
      cross_type nm;
      dot_type   s0;
      dot_type   s1;
      dot_type   t0;
      dot_type   t1;
      logic      a_point;
      logic      b_point;
      logic      p_zero;
   } sum_type;

endpackage

// File: hdl/segint_delta.sv
// Stage one: direction vectors of both segments and the offset between starts.
module segint_delta (
   input  logic                clock,
   input  logic                en,
   input  segint_pkg::req_type req_data,
   output segint_pkg::diff_type diff
);

   segint_pkg::diff_type diff_in;
   segint_pkg::diff_type diff_ff;

   always_comb begin
      diff_in     = diff_ff;
      diff_in.pts = req_data;
      diff_in.dx  = segint_pkg::DELTA_WIDTH'(req_data.a_end_x)
                    - segint_pkg::DELTA_WIDTH'(req_data.a_start_x);
      diff_in.dy  = segint_pkg::DELTA_WIDTH'(req_data.a_end_y)
                    - segint_pkg::DELTA_WIDTH'(req_data.a_start_y);
      diff_in.ex  = segint_pkg::DELTA_WIDTH'(req_data.b_end_x)
                    - segint_pkg::DELTA_WIDTH'(req_data.b_start_x);
      diff_in.ey  = segint_pkg::DELTA_WIDTH'(req_data.b_end_y)
                    - segint_pkg::DELTA_WIDTH'(req_data.b_start_y);
      diff_in.px  = segint_pkg::DELTA_WIDTH'(req_data.b_start_x)
                    - segint_pkg::DELTA_WIDTH'(req_data.a_start_x);
      diff_in.py  = segint_pkg::DELTA_WIDTH'(req_data.b_start_y)
                    - segint_pkg::DELTA_WIDTH'(req_data.a_start_y);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         diff_ff <= diff_in;
      end
   end

   assign diff = diff_ff;

endmodule

// File: hdl/segint_product.sv
// Stage two: the multiplier bank for the cross products and the projections.
module segint_product (
   input  logic                 clock,
   input  logic                 en,
   input  segint_pkg::diff_type diff,
   output segint_pkg::prod_type prod
);

   segint_pkg::prod_type  prod_in;
   segint_pkg::prod_type  prod_ff;
   segint_pkg::delta_type ux;
   segint_pkg::delta_type uy;
   logic                  a_point;

   // A degenerate first segment is projected onto the second one instead.
   assign a_point = (diff.dx == '0) && (diff.dy == '0);
   assign ux      = a_point ? diff.ex : diff.dx;
   assign uy      = a_point ? diff.ey : diff.dy;

   always_comb begin
      prod_in         = prod_ff;
      prod_in.den_p   = diff.dx * diff.ey;
      prod_in.den_q   = diff.dy * diff.ex;
      prod_in.nl_p    = diff.px * diff.ey;
      prod_in.nl_q    = diff.py * diff.ex;
      prod_in.nm_p    = diff.px * diff.dy;
      prod_in.nm_q    = diff.py * diff.dx;
      prod_in.s0_x    = diff.pts.a_start_x * ux;
      prod_in.s0_y    = diff.pts.a_start_y * uy;
      prod_in.s1_x    = diff.pts.a_end_x * ux;
      prod_in.s1_y    = diff.pts.a_end_y * uy;
      prod_in.t0_x    = diff.pts.b_start_x * ux;
      prod_in.t0_y    = diff.pts.b_start_y * uy;
      prod_in.t1_x    = diff.pts.b_end_x * ux;
      prod_in.t1_y    = diff.pts.b_end_y * uy;
      prod_in.a_point = a_point;
      prod_in.b_point = (diff.ex == '0) && (diff.ey == '0);
      prod_in.p_zero  = (diff.px == '0) && (diff.py == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

// File: hdl/segint_reduce.sv
// Stage three: adders that finish the cross products and the projections.
module segint_reduce (
   input  logic                 clock,
   input  logic                 en,
   input  segint_pkg::prod_type prod,
   output segint_pkg::sum_type  sum
);

   segint_pkg::sum_type sum_in;
   segint_pkg::sum_type sum_ff;

   always_comb begin
      sum_in         = sum_ff;
      sum_in.den     = segint_pkg::CROSS_WIDTH'(prod.den_p)
                       - segint_pkg::CROSS_WIDTH'(prod.den_q);
      sum_in.nl      = segint_pkg::CROSS_WIDTH'(prod.nl_p)
                       - segint_pkg::CROSS_WIDTH'(prod.nl_q);
      sum_in.nm      = segint_pkg::CROSS_WIDTH'(prod.nm_p)
                       - segint_pkg::CROSS_WIDTH'(prod.nm_q);
      sum_in.s0      = segint_pkg::DOT_WIDTH'(prod.s0_x)
                       + segint_pkg::DOT_WIDTH'(prod.s0_y);
      sum_in.s1      = segint_pkg::DOT_WIDTH'(prod.s1_x)
                       + segint_pkg::DOT_WIDTH'(prod.s1_y);
      sum_in.t0      = segint_pkg::DOT_WIDTH'(prod.t0_x)
                       + segint_pkg::DOT_WIDTH'(prod.t0_y);
      sum_in.t1      = segint_pkg::DOT_WIDTH'(prod.t1_x)
                       + segint_pkg::DOT_WIDTH'(prod.t1_y);
      sum_in.a_point = prod.a_point;
      sum_in.b_point = prod.b_point;
      sum_in.p_zero  = prod.p_zero;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

// File: hdl/segint_decide.sv
// Stage four: sign and range tests that yield the hit flag and the relation.
module segint_decide (
   input  logic                clock,
   input  logic                en,
   input  segint_pkg::sum_type sum,
   output segint_pkg::rsp_type rsp_data
);

   segint_pkg::rsp_type rsp_in;
   segint_pkg::rsp_type rsp_ff;
   logic                den_zero;
   logic                den_pos;
   logic                nl_ok;
   logic                nm_ok;
   logic                collinear;
   logic                a_reaches_b;
   logic                b_reaches_a;

   assign den_zero = (sum.den == '0);
   assign den_pos  = !den_zero && !sum.den[segint_pkg::CROSS_WIDTH-1];

   // The ratio num/den lies in [0,1] when num sits between zero and den.
   assign nl_ok = den_pos ? (sum.nl >= 0) && (sum.nl <= sum.den)
                          : (sum.nl <= 0) && (sum.nl >= sum.den);
   assign nm_ok = den_pos ? (sum.nm >= 0) && (sum.nm <= sum.den)
                          : (sum.nm <= 0) && (sum.nm >= sum.den);

   // The offset crossed with the direction in use must vanish on a shared line.
   assign collinear = (sum.a_point && sum.b_point) ? sum.p_zero :
                      sum.a_point                  ? (sum.nl == '0) :
                                                     (sum.nm == '0);

   // Max of one interval reaches min of the other iff some endpoint pair does.
   assign a_reaches_b = (sum.s0 >= sum.t0) || (sum.s0 >= sum.t1)
                        || (sum.s1 >= sum.t0) || (sum.s1 >= sum.t1);
   assign b_reaches_a = (sum.t0 >= sum.s0) || (sum.t0 >= sum.s1)
                        || (sum.t1 >= sum.s0) || (sum.t1 >= sum.s1);

   always_comb begin
      rsp_in = rsp_ff;
      if (!den_zero) begin
         rsp_in.relation = segint_pkg::REL_CROSSING;
         rsp_in.hit      = nl_ok && nm_ok;
      end else if (!collinear) begin
         rsp_in.relation = segint_pkg::REL_PARALLEL;
         rsp_in.hit      = 1'b0;
      end else begin
         rsp_in.relation = segint_pkg::REL_COLLINEAR;
         rsp_in.hit      = a_reaches_b && b_reaches_a;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// File: hdl/segment_intersection_test.sv
// Segment intersection test: one request of two 2D segments per clock, four-stage
// pipeline, while the result side does not stall. Each request is registered in turn
// in the delta, product, sum and result registers; the result leaves from the last.
// Stage one forms the direction and offset vectors, stage two is the multiplier
// bank (six cross-product and eight projection products, 17 x 17 bits at most),
// stage three adds them up and stage four makes the exact sign and range tests.
// A stall at the result side holds only the stages that are full, so empty
// stages keep taking requests until the pipeline is packed.
module segment_intersection_test (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  segint_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output segint_pkg::rsp_type rsp_data
);

   segint_pkg::diff_type diff;
   segint_pkg::prod_type prod;
   segint_pkg::sum_type  sum;

   logic [3:0] valid_ff;
   logic [3:0] valid_in;
   logic [3:0] ready;
   logic [3:0] feed;

   // A stage takes new data when it is empty or its successor moves on.
   assign ready[3] = !valid_ff[3] || !rsp_stall;
   assign ready[2] = !valid_ff[2] || ready[3];
   assign ready[1] = !valid_ff[1] || ready[2];
   assign ready[0] = !valid_ff[0] || ready[1];

   assign feed = {valid_ff[2:0], req_valid};

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         valid_in[i] = ready[i] ? feed[i] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[3];

   segint_delta u_delta (
      .clock    (clock),
      .en       (ready[0] && feed[0]),
      .req_data (req_data),
      .diff     (diff)
   );

   segint_product u_product (
      .clock (clock),
      .en    (ready[1] && feed[1]),
      .diff  (diff),
      .prod  (prod)
   );

   segint_reduce u_reduce (
      .clock (clock),
      .en    (ready[2] && feed[2]),
      .prod  (prod),
      .sum   (sum)
   );

   segint_decide u_decide (
      .clock    (clock),
      .en       (ready[3] && feed[3]),
      .sum      (sum),
      .rsp_data (rsp_data)
   );

endmodule

// File: hdl/segint_checker.sv
// Port-level checks for the segment intersection test, bound to the top level.
`include "segment_intersection_test_assert.svh"

module segint_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input segint_pkg::rsp_type rsp_data
);

   logic                                rel_known;
   logic                                par_hit;
   logic                                rsp_held;
   logic [$bits(segint_pkg::rsp_type):0] rsp_word;

   assign rel_known = (rsp_data.relation == segint_pkg::REL_CROSSING)
                      || (rsp_data.relation == segint_pkg::REL_PARALLEL)
                      || (rsp_data.relation == segint_pkg::REL_COLLINEAR);
   assign par_hit   = rsp_data.hit && (rsp_data.relation == segint_pkg::REL_PARALLEL);
   assign rsp_held  = rsp_valid && rsp_stall;
   // A held result must keep both its valid flag and its payload.
   assign rsp_word  = {rsp_valid, rsp_data};

   `SEGINT_ASSERT_NOW(relation_known, clock, reset, rsp_valid, rel_known, "segint: bad relation")
   `SEGINT_ASSERT_NOW(parallel_no_hit, clock, reset, rsp_valid, !par_hit, "segint: parallel hit")
   `SEGINT_ASSERT_NOW(no_stall_when_free, clock, reset, !rsp_held, !req_stall, "segint: bad stall")
   `SEGINT_ASSERT_NEXT(rsp_holds, clock, reset, rsp_held, $stable(rsp_word), "segint: rsp changed")

endmodule

bind segment_intersection_test segint_checker u_segint_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// File: test/segment_intersection_test_test.sv
// Self-checking testbench of the segment intersection test pipeline.
module segment_intersection_test_test;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   segint_pkg::req_type req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   segint_pkg::rsp_type rsp_data;

   segint_pkg::rsp_type pending_touches[$];
   int                  mismatch_count = 0;
   bit                  idle_on = 1'b1;
   int                  stall_left = 0;

   segment_intersection_test u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("FAIL segment_intersection_test");
      $finish;
   end

   // Closed test that num / den lies in [0, 1], with den nonzero.
   function automatic bit within_unit(input longint num, input longint den);
      if (den > 0) begin
         return num >= 0 && num <= den;
      end
      return num <= 0 && num >= den;
   endfunction

   function automatic segint_pkg::rsp_type predict_touch(input segint_pkg::req_type r);
      longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
      longint dx, dy, ex, ey, px, py, den, ux, uy;
      longint s0, s1, t0, t1, amin, amax, bmin, bmax;
      bit     a_point, b_point, on_line;
      segint_pkg::rsp_type res;
      ax0 = r.a_start_x;
      ay0 = r.a_start_y;
      ax1 = r.a_end_x;
      ay1 = r.a_end_y;
      bx0 = r.b_start_x;
      by0 = r.b_start_y;
      bx1 = r.b_end_x;
      by1 = r.b_end_y;
      dx = ax1 - ax0;
      dy = ay1 - ay0;
      ex = bx1 - bx0;
      ey = by1 - by0;
      px = bx0 - ax0;
      py = by0 - ay0;
      den = dx * ey - dy * ex;
      res.hit = 1'b0;
      if (den != 0) begin
         res.relation = segint_pkg::REL_CROSSING;
         res.hit = within_unit(px * ey - py * ex, den) && within_unit(px * dy - py * dx, den);
      end else begin
         a_point = (dx == 0) && (dy == 0);
         b_point = (ex == 0) && (ey == 0);
         ux = dx;
         uy = dy;
         if (a_point && b_point) begin
            on_line = (px == 0) && (py == 0);
         end else if (a_point) begin
            // A single point is projected onto the direction of the second segment.
            on_line = (px * ey - py * ex) == 0;
            ux = ex;
            uy = ey;
         end else begin
            on_line = (dx * py - dy * px) == 0;
         end
         if (!on_line) begin
            res.relation = segint_pkg::REL_PARALLEL;
         end else begin
            s0 = ax0 * ux + ay0 * uy;
            s1 = ax1 * ux + ay1 * uy;
            t0 = bx0 * ux + by0 * uy;
            t1 = bx1 * ux + by1 * uy;
            amin = (s0 < s1) ? s0 : s1;
            amax = (s0 < s1) ? s1 : s0;
            bmin = (t0 < t1) ? t0 : t1;
            bmax = (t0 < t1) ? t1 : t0;
            res.relation = segint_pkg::REL_COLLINEAR;
            res.hit = (amax >= bmin) && (bmax >= amin);
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t: mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // Expectations are formed at the edge where the request is taken.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         pending_touches.push_back(predict_touch(req_data));
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_touches.size() == 0) begin
            report_mismatch("result with no request outstanding");
         end else begin
            segint_pkg::rsp_type want;
            want = pending_touches.pop_front();
            if (rsp_data.hit !== want.hit) begin
               report_mismatch($sformatf("hit %b, wanted %b", rsp_data.hit, want.hit));
            end
            if (rsp_data.relation !== want.relation) begin
               report_mismatch($sformatf("relation %0d, wanted %0d",
                                         rsp_data.relation, want.relation));
            end
         end
      end
   end

   // Result-side back-pressure in random bursts, which begin only while idle_on is set.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 10);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_request(input segint_pkg::req_type item);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_touches.size() != 0);
   endtask

   function automatic segint_pkg::req_type make_seg(input int ax0, ay0, ax1, ay1,
                                                    bx0, by0, bx1, by1);
      segint_pkg::req_type r;
      r.a_start_x = segint_pkg::coord_type'(ax0);
      r.a_start_y = segint_pkg::coord_type'(ay0);
      r.a_end_x   = segint_pkg::coord_type'(ax1);
      r.a_end_y   = segint_pkg::coord_type'(ay1);
      r.b_start_x = segint_pkg::coord_type'(bx0);
      r.b_start_y = segint_pkg::coord_type'(by0);
      r.b_end_x   = segint_pkg::coord_type'(bx1);
      r.b_end_y   = segint_pkg::coord_type'(by1);
      return r;
   endfunction

   function automatic segint_pkg::req_type make_full_range();
      return segint_pkg::req_type'({$urandom, $urandom, $urandom, $urandom});
   endfunction

   function automatic segint_pkg::req_type make_small_grid();
      return make_seg($urandom_range(0, 16) - 8, $urandom_range(0, 16) - 8,
                      $urandom_range(0, 16) - 8, $urandom_range(0, 16) - 8,
                      $urandom_range(0, 16) - 8, $urandom_range(0, 16) - 8,
                      $urandom_range(0, 16) - 8, $urandom_range(0, 16) - 8);
   endfunction

   // All four points on one line; with an offset the second segment is shifted by a small random step.
   function automatic segint_pkg::req_type make_on_line(input bit offset_b);
      int bx, by, ux, uy, wx, wy, k0, k1, k2, k3, span;
      span = ($urandom_range(0, 3) == 0) ? 4 : 300;
      bx = $urandom_range(0, 2000) - 1000;
      by = $urandom_range(0, 2000) - 1000;
      ux = $urandom_range(0, 80) - 40;
      uy = $urandom_range(0, 80) - 40;
      k0 = $urandom_range(0, 2 * span) - span;
      k1 = $urandom_range(0, 2 * span) - span;
      k2 = $urandom_range(0, 2 * span) - span;
      k3 = $urandom_range(0, 2 * span) - span;
      wx = offset_b ? $urandom_range(0, 20) - 10 : 0;
      wy = offset_b ? $urandom_range(0, 20) - 10 : 0;
      return make_seg(bx + k0 * ux, by + k0 * uy, bx + k1 * ux, by + k1 * uy,
                      bx + k2 * ux + wx, by + k2 * uy + wy,
                      bx + k3 * ux + wx, by + k3 * uy + wy);
   endfunction

   // One endpoint of the second segment is copied from the first.
   function automatic segint_pkg::req_type make_shared_end();
      segint_pkg::req_type r;
      r = ($urandom_range(0, 1) == 0) ? make_full_range() : make_small_grid();
      case ($urandom_range(0, 3))
         0: begin
            r.b_start_x = r.a_start_x;
            r.b_start_y = r.a_start_y;
         end
         1: begin
            r.b_start_x = r.a_end_x;
            r.b_start_y = r.a_end_y;
         end
         2: begin
            r.b_end_x = r.a_start_x;
            r.b_end_y = r.a_start_y;
         end
         default: begin
            r.b_end_x = r.a_end_x;
            r.b_end_y = r.a_end_y;
         end
      endcase
      return r;
   endfunction

   function automatic segint_pkg::req_type make_mixed();
      case ($urandom_range(0, 4))
         0: return make_full_range();
         1: return make_small_grid();
         2: return make_on_line(1'b0);
         3: return make_on_line(1'b1);
         default: return make_shared_end();
      endcase
   endfunction

   task automatic test_directed_cases();
      segint_pkg::req_type cases[$];
      cases.push_back(make_seg(0, 0, 0, 0, 0, 0, 0, 0));
      cases.push_back(make_seg(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
      cases.push_back(make_seg(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
      cases.push_back(make_seg(0, 0, 10, 10, 0, 10, 10, 0));
      cases.push_back(make_seg(0, 0, 1, 1, 5, 0, 4, 1));
      cases.push_back(make_seg(0, 0, 4, 0, 4, -3, 4, 3));
      cases.push_back(make_seg(0, 0, 4, 4, 2, 2, 6, 0));
      cases.push_back(make_seg(0, 0, 10, 0, 5, 5, 5, -5));
      cases.push_back(make_seg(0, 0, 10, 0, 5, -5, 5, 5));
      cases.push_back(make_seg(0, 0, 10, 0, 0, 1, 10, 1));
      cases.push_back(make_seg(0, 0, 10, 0, 5, 0, 15, 0));
      cases.push_back(make_seg(0, 0, 5, 5, 5, 5, 9, 9));
      cases.push_back(make_seg(0, 0, 2, 0, 3, 0, 9, 0));
      cases.push_back(make_seg(10, 10, 0, 0, 3, 3, 4, 4));
      // First segment shrunk to a point: on, off and beyond the second.
      cases.push_back(make_seg(3, 3, 3, 3, 0, 0, 6, 6));
      cases.push_back(make_seg(3, 4, 3, 4, 0, 0, 6, 6));
      cases.push_back(make_seg(9, 9, 9, 9, 0, 0, 6, 6));
      cases.push_back(make_seg(7, -7, 7, -7, 7, -7, 7, -7));
      cases.push_back(make_seg(7, -7, 7, -7, 1, 2, 1, 2));
      // Second segment shrunk to a point.
      cases.push_back(make_seg(0, 0, 8, 4, 4, 2, 4, 2));
      cases.push_back(make_seg(0, 0, 8, 4, 4, 3, 4, 3));
      cases.push_back(make_seg(0, 0, 8, 4, -2, -1, -2, -1));
      cases.push_back(make_seg(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
      cases.push_back(make_seg(-32768, -32768, 32767, 32767, 32767, 32767, -32768, -32768));
      cases.push_back(make_seg(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767));
      foreach (cases[i]) send_request(cases[i]);
   endtask

   task automatic test_full_range();
      for (int i = 0; i < 500; i++) begin
         if (i % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
         send_request(make_full_range());
      end
   endtask

   task automatic test_small_grid();
      for (int i = 0; i < 350; i++) begin
         if (i % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
         send_request(make_small_grid());
      end
   endtask

   task automatic test_on_line();
      for (int i = 0; i < 450; i++) begin
         if (i % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
         send_request(make_on_line($urandom_range(0, 2) == 0));
      end
   endtask

   task automatic test_shared_endpoints();
      idle_on = 1'b1;
      for (int i = 0; i < 200; i++) send_request(make_shared_end());
   endtask

   task automatic test_drain_pause();
      idle_on = 1'b1;
      for (int i = 0; i < 150; i++) begin
         send_request(make_mixed());
         if (i % 50 == 49) wait_for_drain();
      end
   endtask

   task automatic test_back_to_back();
      idle_on = 1'b0;
      for (int i = 0; i < 300; i++) send_request(make_mixed());
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_full_range();
      test_small_grid();
      test_on_line();
      test_shared_endpoints();
      test_drain_pause();
      test_back_to_back();
      wait_for_drain();
      repeat (8) @(posedge clock);
      if (pending_touches.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", pending_touches.size()));
      end
      if (mismatch_count == 0) begin
         $display("PASS segment_intersection_test");
      end else begin
         $display("FAIL segment_intersection_test");
      end
      $finish;
   end

endmodule
